@@ src/packed_sample_gamma_to_8bit_defines.svh @@
// assertion macros shared by the gamma block
`ifndef PACKED_SAMPLE_GAMMA_TO_8BIT_DEFINES_SVH
`define PACKED_SAMPLE_GAMMA_TO_8BIT_DEFINES_SVH

// checked outside reset
`define GAM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked during reset as well
`define GAM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/gam_pkg.sv @@
package gam_pkg;

  // sample width modes
  localparam logic [1:0] MODE_8  = 2'd0;
  localparam logic [1:0] MODE_12 = 2'd1;
  localparam logic [1:0] MODE_16 = 2'd2;

  // register indexes
  localparam logic REG_MODE  = 1'b0;
  localparam logic REG_GAMMA = 1'b1;

  localparam logic [15:0] GAMMA_RESET = 16'd4096;
  localparam logic [3:0]  LOW_NIBBLE  = 4'hF;

  // largest supported fraction width
  localparam int ROOT_MAX = 24;
  localparam int ROOT_IW  = 5;

  typedef logic [30:0] root_tab_t [ROOT_MAX];

  // completed sample handed from the unpacker to the math core
  typedef struct packed {
    logic        valid;
    logic [1:0]  mode;
    logic [15:0] x;
  } sample_t;

  // core status seen by the top level
  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned res;
    longint unsigned bv;
    longint unsigned vv;
    res = 0;
    bv  = 64'd1 << 62;
    vv  = v;
    while (bv > vv) bv = bv >> 2;
    while (bv != 0) begin
      if (vv >= res + bv) begin
        vv  = vv - (res + bv);
        res = (res >> 1) + bv;
      end else begin
        res = res >> 1;
      end
      bv = bv >> 2;
    end
    return res;
  endfunction

  // c_1 = sqrt(2^59), c_(k+1) = sqrt(c_k * 2^30), entry k-1 holds c_k
  function automatic root_tab_t build_roots();
    root_tab_t t;
    longint unsigned c;
    c = floor_sqrt(64'd1 << 59);
    for (int k = 0; k < ROOT_MAX; k++) begin
      t[k] = c[30:0];
      c = floor_sqrt(c << 30);
    end
    return t;
  endfunction

  localparam root_tab_t ROOTS = build_roots();

  // elaboration-time log2 of a constant, same procedure as the core
  function automatic logic [31:0] log2_fix(input int unsigned v, input int unsigned fb);
    int e;
    longint unsigned m;
    longint unsigned frac;
    e = 15;
    frac = 0;
    while (e > 0 && ((v >> e) & 1) == 0) e = e - 1;
    m = longint'(v) << (30 - e);
    for (int i = 0; i < fb; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        frac = frac | 1;
        m = m >> 1;
      end
    end
    return 32'((longint'(e) << fb) | frac);
  endfunction

endpackage

@@ src/gam_mul.sv @@
module gam_mul (
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);

  // the one multiplier shared by the log, gamma and exp steps of the core
  assign p = {32'd0, a} * {32'd0, b};

endmodule

@@ src/gam_unpack.sv @@
module gam_unpack (
  input  logic             clk,
  input  logic             rst,
  input  logic             clr,
  input  logic             accept,
  input  logic [7:0]       data,
  input  logic [1:0]       mode,
  output gam_pkg::sample_t smp
);

  logic [1:0] byte_phase, byte_phase_next;
  logic [7:0] held_bits, held_bits_next;

  // assemble samples from bytes
  always_comb begin
    byte_phase_next = byte_phase;
    held_bits_next  = held_bits;
    smp.valid = 1'b0;
    smp.mode  = mode;
    smp.x     = 16'd0;
    case (mode)
      gam_pkg::MODE_8: begin
        byte_phase_next = 2'd0;
        smp.valid = 1'b1;
        smp.x     = {8'd0, data};
      end
      gam_pkg::MODE_12: begin
        if (byte_phase == 2'd1) begin
          smp.valid = 1'b1;
          smp.x     = {4'd0, held_bits, data[7:4]};
          held_bits_next  = {4'd0, data[3:0]};
          byte_phase_next = 2'd2;
        end else if (byte_phase == 2'd2) begin
          smp.valid = 1'b1;
          smp.x     = {4'd0, held_bits[3:0] & gam_pkg::LOW_NIBBLE, data};
          held_bits_next  = 8'd0;
          byte_phase_next = 2'd0;
        end else begin
          held_bits_next  = data;
          byte_phase_next = 2'd1;
        end
      end
      gam_pkg::MODE_16: begin
        if (byte_phase == 2'd1) begin
          smp.valid = 1'b1;
          smp.x     = {held_bits, data};
          held_bits_next  = 8'd0;
          byte_phase_next = 2'd0;
        end else begin
          held_bits_next  = data;
          byte_phase_next = 2'd1;
        end
      end
      default: begin
        byte_phase_next = 2'd0;
        held_bits_next  = 8'd0;
      end
    endcase
    smp.valid = smp.valid & accept;
  end

  // phase and partial byte
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      byte_phase <= 2'd0;
      held_bits  <= 8'd0;
    end else if (accept) begin
      byte_phase <= byte_phase_next;
      held_bits  <= held_bits_next;
    end
  end

endmodule

@@ src/gam_core.sv @@
module gam_core #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  gam_pkg::sample_t    smp,
  input  logic [15:0]         gamma,
  input  logic                take,
  output gam_pkg::core_stat_t stat,
  output logic [7:0]          result
);

  localparam int F  = FRACTION_BITS;
  localparam int LW = F + 4;
  localparam int CW = (F > 1) ? $clog2(F) : 1;
  localparam int RIW = gam_pkg::ROOT_IW;
  localparam logic [CW-1:0] CNT_LAST = CW'(F - 1);
  localparam logic [LW-1:0] LOGM8  = LW'(gam_pkg::log2_fix(255, F));
  localparam logic [LW-1:0] LOGM12 = LW'(gam_pkg::log2_fix(4095, F));
  localparam logic [LW-1:0] LOGM16 = LW'(gam_pkg::log2_fix(65535, F));

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_LOG  = 6'b000010,
    ST_MULG = 6'b000100,
    ST_EXP  = 6'b001000,
    ST_FIN  = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t          state, state_next;
  logic [30:0]     m;
  logic [3:0]      e;
  logic [F-1:0]    frac;
  logic [1:0]      mode;
  logic [30:0]     r;
  logic [F-1:0]    fsh;
  logic [2:0]      q;
  logic [CW-1:0]   cnt;

  logic [31:0]     mul_a, mul_b;
  logic [63:0]     prod;
  logic [3:0]      lead;
  logic [4:0]      sh;
  logic [30:0]     m0;
  logic [31:0]     msq;
  logic [LW-1:0]   logm, negl;
  logic [F+7:0]    dval;
  logic [38:0]     y39, ysh;
  logic [5:0]      yshamt;

  gam_mul u_mul (.a(mul_a), .b(mul_b), .p(prod));

  // top bit of the sample and its normalized mantissa
  always_comb begin
    lead = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (smp.x[i]) lead = 4'(i);
    end
    sh = 5'd30 - {1'b0, lead};
    m0 = 31'({15'd0, smp.x} << sh);
  end

  // log of the full-scale value for the current mode, less the log of the sample
  always_comb begin
    case (mode)
      gam_pkg::MODE_12: logm = LOGM12;
      gam_pkg::MODE_16: logm = LOGM16;
      default:          logm = LOGM8;
    endcase
    negl = logm - {e, frac};
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = {1'b0, m};
    mul_b = {1'b0, m};
    unique case (state)
      ST_MULG: begin
        mul_a = {16'd0, gamma};
        mul_b = 32'(negl);
      end
      ST_EXP: begin
        mul_a = {1'b0, r};
        mul_b = {1'b0, gam_pkg::ROOTS[RIW'(cnt)]};
      end
      default: ;
    endcase
  end

  assign msq    = prod[61:30];
  assign dval   = prod[F+19:12];
  assign y39    = {r, 8'd0} - {8'd0, r};
  assign yshamt = 6'd30 + {3'd0, q};
  assign ysh    = y39 >> yshamt;

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (smp.valid) state_next = (smp.x == 16'd0) ? ST_DONE : ST_LOG;
      ST_LOG:  if (cnt == CNT_LAST) state_next = ST_MULG;
      ST_MULG: state_next = (|dval[F+7:F+3]) ? ST_DONE : ST_EXP;
      ST_EXP:  if (cnt == CNT_LAST) state_next = ST_FIN;
      ST_FIN:  state_next = ST_DONE;
      ST_DONE: if (take) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        mode <= smp.mode;
        e    <= lead;
        m    <= m0;
        frac <= '0;
        cnt  <= '0;
        result <= (gamma == 16'd0) ? 8'd255 : 8'd0;
      end
      ST_LOG: begin
        // square, then renormalize and take one fraction bit
        if (msq[31]) m <= msq[31:1];
        else         m <= msq[30:0];
        frac <= {frac[F-2:0], msq[31]};
        cnt  <= cnt + CW'(1);
      end
      ST_MULG: begin
        q      <= dval[F+2:F];
        fsh    <= dval[F-1:0];
        r      <= 31'd1 << 30;
        cnt    <= '0;
        result <= 8'd0;
      end
      ST_EXP: begin
        if (fsh[F-1]) r <= prod[60:30];
        fsh <= fsh << 1;
        cnt <= cnt + CW'(1);
      end
      ST_FIN: begin
        result <= (|ysh[38:8]) ? 8'd255 : ysh[7:0];
      end
      default: ;
    endcase
  end

  assign stat.busy = (state != ST_IDLE);
  assign stat.done = (state == ST_DONE);

endmodule

@@ src/packed_sample_gamma_to_8bit.sv @@
// channel   dir  handshake          payload
// s_axis    in   s_tvalid/s_tready  s_tdata = stream_byte
// m_axis    out  m_tvalid/m_tready  m_tdata = pixel_value
// apb       in   psel/penable       paddr 0 = sample_width_mode, 4 = gamma_exponent
//
// a byte that completes no sample is only stored in the unpacker
// a completed sample runs through the shared multiplier: a setup step,
// FRACTION_BITS log steps, one gamma multiply, FRACTION_BITS exp steps and
// a scale step that loads the result; a zero sample or overflow ends early
// s_tready is low while the core works or holds a result not yet taken
// synchronous reset clears phase, held bits, core state and m_tvalid
`include "packed_sample_gamma_to_8bit_defines.svh"

module packed_sample_gamma_to_8bit #(
  parameter int FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] stream_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] pixel_value
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [1:0]          sample_width_mode;
  logic [15:0]         gamma_exponent;
  logic                wr, mode_wr, s_acc, take;
  gam_pkg::sample_t    smp;
  gam_pkg::core_stat_t core_st;
  logic [7:0]          result;

  // register port
  assign pready  = 1'b1;
  assign wr      = psel & penable & pwrite & pready;
  assign mode_wr = wr & (paddr[2] == gam_pkg::REG_MODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_width_mode <= gam_pkg::MODE_8;
      gamma_exponent    <= gam_pkg::GAMMA_RESET;
    end else if (wr) begin
      unique case (paddr[2])
        gam_pkg::REG_MODE:  sample_width_mode <= pwdata[1:0];
        gam_pkg::REG_GAMMA: gamma_exponent    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      gam_pkg::REG_MODE:  prdata = {30'd0, sample_width_mode};
      gam_pkg::REG_GAMMA: prdata = {16'd0, gamma_exponent};
      default:            prdata = 32'd0;
    endcase
  end

  // input side
  assign s_tready = !core_st.busy;
  assign s_acc    = s_tvalid & s_tready;

  gam_unpack u_unpack (
    .clk(clk), .rst(rst), .clr(mode_wr), .accept(s_acc),
    .data(s_tdata), .mode(sample_width_mode), .smp(smp)
  );

  gam_core #(.FRACTION_BITS(FRACTION_BITS)) u_core (
    .clk(clk), .rst(rst), .smp(smp), .gamma(gamma_exponent),
    .take(take), .stat(core_st), .result(result)
  );

  // output register
  assign take = core_st.done & (!m_tvalid | m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) m_tdata <= result;
  end

  `GAM_ASSERT(a_sample_starts_core, smp.valid |=> core_st.busy, "sample did not start core")
  `GAM_ASSERT(a_done_held, (core_st.done && m_tvalid && !m_tready) |=> core_st.done, "result dropped")
  `GAM_ASSERT_RST(a_reset_clear, rst |=> (!m_tvalid && !core_st.busy), "reset left activity")

endmodule
